>>> design/pus_pkg.sv
// Package for the page update scheduler: types, constants and the record key function.
`default_nettype none
package pus_pkg;

  localparam int MAX_PAGES = 32;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  localparam logic [16:0] KEY_VISIBLE = 17'd100000;
  localparam logic [16:0] KEY_INVALID = 17'd10000;
  localparam logic [31:0] AGE_CAP = 32'd1000;

  localparam logic [31:0] RST_CURRENT_FRAME = 32'd0;
  localparam logic [31:0] RST_MAX_AGE = 32'd60;
  localparam logic [6:0] RST_BUDGET = 7'd8;

  typedef enum logic [1:0] {
    CFG_CURRENT_FRAME = 2'd0,
    CFG_MAX_AGE_FRAMES = 2'd1,
    CFG_UPDATE_BUDGET = 2'd2,
    CFG_SERVICE_ALL = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] page_handle;
    logic visible_flag;
    logic valid_flag;
    logic [9:0] error_milli;
    logic [31:0] last_shaded_frame;
    logic last_page;
  } in_item_t;

  typedef struct packed {
    logic [15:0] selected_handle;
    logic handle_present;
    logic last_result;
    logic [6:0] pages_held;
    logic [6:0] invalid_count;
    logic [31:0] oldest_skipped_age;
    logic overflow_flag;
  } out_item_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [16:0] key;
    logic starved;
    logic [31:0] age;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shf;
    logic clr;
  } chain_ctrl_t;

  function automatic logic [16:0] rank_key(logic visible, logic valid, logic [9:0] err,
                                           logic [31:0] age);
    logic [9:0] capped;
    capped = (age < AGE_CAP) ? age[9:0] : AGE_CAP[9:0];
    rank_key = (visible ? KEY_VISIBLE : 17'd0) + (valid ? 17'd0 : KEY_INVALID)
               + {7'd0, err} + {7'd0, capped};
  endfunction

endpackage
`default_nettype wire

>>> design/pus_cell.sv
// One sorted slot of the insertion chain: compares the broadcast record and shifts.
`default_nettype none
module pus_cell
  import pus_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire chain_ctrl_t ctrl,
  input  wire entry_t      new_entry,
  input  wire logic        prev_outr,
  input  wire entry_t      prev_entry,
  input  wire logic        prev_valid,
  input  wire entry_t      next_entry,
  input  wire logic        next_valid,
  output logic             outr,
  output entry_t           entry,
  output logic             valid
);

  entry_t entry_r, entry_nxt;
  logic valid_r, valid_nxt;
  logic beats;

  always_comb begin
    if (new_entry.starved != entry_r.starved) begin
      beats = new_entry.starved;
    end else if (new_entry.key != entry_r.key) begin
      beats = new_entry.key > entry_r.key;
    end else begin
      beats = new_entry.handle < entry_r.handle;
    end
    outr = !valid_r || beats;
  end

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins) begin
      if (prev_outr) begin
        entry_nxt = prev_entry;
        valid_nxt = prev_valid;
      end else if (outr) begin
        entry_nxt = new_entry;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shf) begin
      entry_nxt = next_entry;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

>>> design/pus_chain.sv
// Row of sorted cells; rank order runs from cell 0, which is the read-out head.
`default_nettype none
module pus_chain
  import pus_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire chain_ctrl_t ctrl,
  input  wire entry_t      new_entry,
  output entry_t           head
);

  entry_t entries [MAX_PAGES];
  logic valids [MAX_PAGES];
  logic outrs [MAX_PAGES];

  for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
    logic p_outr, n_valid, p_valid;
    entry_t p_entry, n_entry;

    if (i == 0) begin : g_first
      assign p_outr = 1'b0;
      assign p_entry = new_entry;
      assign p_valid = 1'b0;
    end else begin : g_mid
      assign p_outr = outrs[i-1];
      assign p_entry = entries[i-1];
      assign p_valid = valids[i-1];
    end

    if (i == MAX_PAGES - 1) begin : g_last
      assign n_entry = new_entry;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_entry = entries[i+1];
      assign n_valid = valids[i+1];
    end

    pus_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_outr  (p_outr),
      .prev_entry (p_entry),
      .prev_valid (p_valid),
      .next_entry (n_entry),
      .next_valid (n_valid),
      .outr       (outrs[i]),
      .entry      (entries[i]),
      .valid      (valids[i])
    );
  end

  assign head = entries[0];

endmodule
`default_nettype wire

>>> design/page_update_scheduler_top.sv
// Top level of the page update scheduler: config registers, record staging, pass control.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------
//   input    | start / busy       | in_data
//   result   | out_valid strobe   | out_data
//   config   | cfg_we             | cfg_index, cfg_wdata
//
// Loading takes one record per cycle while busy is low; each record is registered
// in the stage, then inserted into the cell chain unless the chain is full. After the
// last record the block inserts it (S_INS), shifts the loaded pages out through
// cell 0 (S_DRAIN) and issues the final result (S_FINAL), with busy high throughout.
// Reset clears control state and the cell valid bits. Results cannot be stalled.
`default_nettype none
module page_update_scheduler_top
  import pus_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_INS,
    S_DRAIN,
    S_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] cur_frame_r, cur_frame_nxt;
  logic [31:0] max_age_r, max_age_nxt;
  logic [6:0] budget_r, budget_nxt;
  logic svc_all_r, svc_all_nxt;

  entry_t stage_r, stage_nxt;
  logic stage_keep_r, stage_keep_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] inv_r, inv_nxt;
  logic ovf_r, ovf_nxt;
  logic [CNT_W-1:0] sel_r, sel_nxt;
  logic [CNT_W-1:0] t_r, t_nxt;
  logic [31:0] oldest_r, oldest_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic accept;
  logic [31:0] age;
  logic [6:0] count_ext;
  chain_ctrl_t ctrl;
  entry_t head;

  assign accept = start && (state_r == S_LOAD);
  assign age = (cur_frame_r > in_data.last_shaded_frame)
               ? cur_frame_r - in_data.last_shaded_frame : 32'd0;
  assign count_ext = 7'(count_r);

  assign ctrl.ins = (state_r == S_LOAD || state_r == S_INS) && stage_keep_r;
  assign ctrl.shf = (state_r == S_DRAIN);
  assign ctrl.clr = (state_r == S_FINAL);

  pus_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .new_entry (stage_r),
    .head      (head)
  );

  always_comb begin
    state_nxt = state_r;
    cur_frame_nxt = cur_frame_r;
    max_age_nxt = max_age_r;
    budget_nxt = budget_r;
    svc_all_nxt = svc_all_r;
    stage_nxt = stage_r;
    stage_keep_nxt = 1'b0;
    count_nxt = count_r;
    inv_nxt = inv_r;
    ovf_nxt = ovf_r;
    sel_nxt = sel_r;
    t_nxt = t_r;
    oldest_nxt = oldest_r;
    hold_nxt = hold_r;
    out_valid_nxt = 1'b0;
    out_data_nxt = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_CURRENT_FRAME:  cur_frame_nxt = cfg_wdata;
        CFG_MAX_AGE_FRAMES: max_age_nxt = cfg_wdata;
        CFG_UPDATE_BUDGET:  budget_nxt = cfg_wdata[6:0];
        CFG_SERVICE_ALL:    svc_all_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          stage_nxt.handle = in_data.page_handle;
          stage_nxt.age = age;
          stage_nxt.starved = age >= max_age_r;
          stage_nxt.key = rank_key(in_data.visible_flag, in_data.valid_flag,
                                   in_data.error_milli, age);
          if (count_r < CNT_W'(MAX_PAGES)) begin
            stage_keep_nxt = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            inv_nxt = inv_r + CNT_W'(!in_data.valid_flag);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_page) begin
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        if (svc_all_r || budget_r >= count_ext) begin
          sel_nxt = count_r;
        end else begin
          sel_nxt = CNT_W'(budget_r);
        end
        t_nxt = '0;
        oldest_nxt = '0;
        state_nxt = (count_r == '0) ? S_FINAL : S_DRAIN;
      end
      S_DRAIN: begin
        if (t_r < sel_r) begin
          if (t_r + CNT_W'(1) == sel_r) begin
            hold_nxt = head.handle;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt = '0;
            out_data_nxt.selected_handle = head.handle;
            out_data_nxt.handle_present = 1'b1;
          end
        end else if (head.age > oldest_r) begin
          oldest_nxt = head.age;
        end
        t_nxt = t_r + CNT_W'(1);
        if (t_r + CNT_W'(1) == count_r) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.selected_handle = (sel_r == '0) ? 16'd0 : hold_r;
        out_data_nxt.handle_present = (sel_r != '0);
        out_data_nxt.last_result = 1'b1;
        out_data_nxt.pages_held = count_ext;
        out_data_nxt.invalid_count = 7'(inv_r);
        out_data_nxt.oldest_skipped_age = oldest_r;
        out_data_nxt.overflow_flag = ovf_r;
        count_nxt = '0;
        inv_nxt = '0;
        ovf_nxt = 1'b0;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    sel_r <= sel_nxt;
    t_r <= t_nxt;
    oldest_r <= oldest_nxt;
    hold_r <= hold_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r <= S_LOAD;
      cur_frame_r <= RST_CURRENT_FRAME;
      max_age_r <= RST_MAX_AGE;
      budget_r <= RST_BUDGET;
      svc_all_r <= 1'b0;
      stage_keep_r <= 1'b0;
      count_r <= '0;
      inv_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_frame_r <= cur_frame_nxt;
      max_age_r <= max_age_nxt;
      budget_r <= budget_nxt;
      svc_all_r <= svc_all_nxt;
      stage_keep_r <= stage_keep_nxt;
      count_r <= count_nxt;
      inv_r <= inv_nxt;
      ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire
